// File: src/cht_pkg.sv
// shared constants and types for the chained hash table
`default_nettype none
package cht_pkg;

  localparam int MAX_BUCKETS = 16;
  localparam int POOL_NODES  = 32;

  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10);

  // bucket index, divisor, pool pointer and key bit index widths
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DIV_W  = BKT_W + 1;
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int PTR_W  = $clog2(POOL_NODES + 1);
  localparam int BIT_W  = $clog2(KEY_W);

  // operation codes carried by in_kind
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // one pool node as stored in the node memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [PTR_W-1:0]   link;
  } node_t;

  localparam int NODE_BITS = KEY_W + VALUE_W + PTR_W;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic mod_step;   // one remainder bit
    logic ins_write;  // link a new node at the bucket head
    logic from_link;  // next node address from the link just read
  } cht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;
    logic mod_last;
    logic pool_full;
    logic head_zero;
    logic key_match;
    logic link_zero;
  } cht_stat_t;

endpackage
`default_nettype wire

// File: src/cht_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/cht_dp.sv
// datapath: serial modulo, bucket heads, node pool and key compare
`default_nettype none
module cht_dp import cht_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                in_kind,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire cht_cmd_t            cmd,
  output cht_stat_t                stat
);

  logic [CFG_W-1:0]   bcount_r;
  logic               kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [BKT_W-1:0]   rem_r;
  logic [BKT_W-1:0]   rem_nxt;
  logic [BIT_W-1:0]   bit_r;
  logic [PTR_W-1:0]   used_r;
  logic [PTR_W-1:0]   head_r [MAX_BUCKETS];
  logic [DIV_W-1:0]   divisor;
  logic [DIV_W-1:0]   trial;
  logic [PTR_W-1:0]   head_sel;
  logic [PTR_W-1:0]   next_ptr;
  logic [NODE_W-1:0]  raddr;
  node_t              wnode;
  node_t              rnode;

  // bucket count clamped to 1..MAX_BUCKETS
  always_comb begin
    priority if (bcount_r == '0) begin
      divisor = DIV_W'(1);
    end else if (int'(bcount_r) > MAX_BUCKETS) begin
      divisor = DIV_W'(MAX_BUCKETS);
    end else begin
      divisor = DIV_W'(bcount_r);
    end
  end

  // restoring remainder step, one key bit per cycle from the top
  assign trial   = {rem_r, key_r[bit_r]};
  assign rem_nxt = (trial >= divisor) ? BKT_W'(trial - divisor) : BKT_W'(trial);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= CFG_RESET;
    end else if (cfg_we) begin
      bcount_r <= cfg_wdata;
    end
  end

  // request capture and remainder iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      key_r   <= in_key;
      value_r <= in_value;
      rem_r   <= '0;
      bit_r   <= BIT_W'(KEY_W - 1);
    end else if (cmd.mod_step) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - BIT_W'(1);
    end
  end

  // bucket heads and pool fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        head_r[i] <= '0;
      end
    end else if (cmd.ins_write) begin
      head_r[rem_r] <= used_r + PTR_W'(1);
      used_r        <= used_r + PTR_W'(1);
    end
  end

  assign head_sel = head_r[rem_r];

  // node memory, new node points at the old head
  assign wnode.key   = key_r;
  assign wnode.value = value_r;
  assign wnode.link  = head_sel;

  assign next_ptr = cmd.from_link ? rnode.link : head_sel;
  assign raddr    = NODE_W'(next_ptr - PTR_W'(1));

  cht_ram #(
    .WIDTH (NODE_BITS),
    .DEPTH (POOL_NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (used_r[NODE_W-1:0]),
    .wdata (wnode),
    .raddr (raddr),
    .rdata (rnode)
  );

  // status back to the controller
  assign stat.is_search = (kind_r == KIND_SEARCH);
  assign stat.mod_last  = (bit_r == '0);
  assign stat.pool_full = (int'(used_r) >= POOL_NODES);
  assign stat.head_zero = (head_sel == '0);
  assign stat.key_match = (rnode.key == key_r);
  assign stat.link_zero = (rnode.link == '0);

endmodule
`default_nettype wire

// File: src/cht_ctrl.sv
// controller state machine for insert and search requests
`default_nettype none
module cht_ctrl import cht_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire cht_stat_t stat,
  output cht_cmd_t       cmd,
  output logic           out_strobe,
  output logic           out_found,
  output logic           out_status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;
  logic   found_r, found_nxt;
  logic   status_r, status_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state, commands and result
  always_comb begin
    state_nxt     = state_r;
    strobe_nxt    = 1'b0;
    found_nxt     = found_r;
    status_nxt    = status_r;
    cmd.load      = 1'b0;
    cmd.mod_step  = 1'b0;
    cmd.ins_write = 1'b0;
    cmd.from_link = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!stat.is_search) begin
          cmd.ins_write = !stat.pool_full;
          strobe_nxt    = 1'b1;
          found_nxt     = 1'b0;
          status_nxt    = stat.pool_full;
          state_nxt     = ST_IDLE;
        end else if (stat.head_zero) begin
          strobe_nxt = 1'b1;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.from_link = 1'b1;
        if (stat.key_match || stat.link_zero) begin
          strobe_nxt = 1'b1;
          found_nxt  = stat.key_match;
          status_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      found_r  <= 1'b0;
      status_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_found  = found_r;
  assign out_status = status_r;

  // a result comes only once the request has finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // one result per request, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back to back result strobes");

  // a dropped insert never reports a hit
  a_drop_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> !out_found)
    else $error("dropped insert reported found");

endmodule
`default_nettype wire

// File: src/chained_hash_table_core.sv
// top level of the chained hash table core
//
//  channel   ports                                   transfer
//  request   start, busy, in_kind, in_key, in_value  start && !busy
//  result    out_strobe, out_found, out_status       out_strobe, one cycle
//  config    cfg_we, cfg_wdata                       cfg_we
//
// every request first runs a bit-serial key modulo that selects a bucket, then
// a bucket head lookup; an insert ends there.
// a search then reads one chain node per cycle from the node ram until the key
// matches or the end of the chain (or an empty bucket) is reached.
// synchronous active-low reset empties all buckets and the pool; no clearing
// pass is needed. the receiver cannot stall: each result shows for one cycle.
`default_nettype none
module chained_hash_table_core import cht_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_kind,
  input  wire logic [KEY_W-1:0]          in_key,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_strobe,
  output logic                           out_found,
  output logic                           out_status
);

  cht_cmd_t  cmd;
  cht_stat_t stat;

  // sequencing
  cht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd),
    .out_strobe (out_strobe),
    .out_found  (out_found),
    .out_status (out_status)
  );

  // storage and arithmetic
  cht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_kind   (in_kind),
    .in_key    (in_key),
    .in_value  (in_value),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
